// ===== rtl/core/stic_pkg.sv =====
// ----------------------------------------------------------------------------
// stic_pkg
// Shared types and constants for the SLIP tag ID collector.
// ----------------------------------------------------------------------------
package stic_pkg;

  localparam logic [7:0] SlipEnd        = 8'hC0;
  localparam logic [7:0] SlipEsc        = 8'hDB;
  localparam logic [7:0] SlipEscapedEnd = 8'hDC;
  localparam logic [7:0] SlipEscapedEsc = 8'hDD;

  localparam int unsigned IdBytes  = 12;
  localparam int unsigned ByteCntW = $clog2(IdBytes);
  localparam int unsigned UpperW   = 64;
  localparam int unsigned LowerW   = 32;
  localparam int unsigned EntryIdxW = 6;

  localparam logic [ByteCntW-1:0] LastByte = ByteCntW'(IdBytes - 1);

  typedef struct packed {
    logic [UpperW-1:0] upper;
    logic [LowerW-1:0] lower;
  } id_t;

  typedef struct packed {
    logic frame_end;
    logic id_done;
  } unslip_evt_t;

  typedef struct packed {
    logic shift;
    logic write;
    logic active;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_DRAIN
  } state_e;

endpackage

// ===== rtl/core/stic_unslip.sv =====
// ----------------------------------------------------------------------------
// stic_unslip
// Removes SLIP escaping and assembles 12 data bytes into one tag ID.
// ----------------------------------------------------------------------------
module stic_unslip (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           rx_byte_i,
  output stic_pkg::unslip_evt_t evt_o,
  output stic_pkg::id_t        id_o
);
  import stic_pkg::*;

  logic                          esc_q, esc_d;
  logic [ByteCntW-1:0]           cnt_q, cnt_d;
  logic [IdBytes-1:0][7:0]       asm_q;
  logic [IdBytes-1:0][7:0]       full_bytes;
  logic [7:0]                    data_byte;
  logic                          is_end;
  logic                          is_esc;
  logic                          is_data;

  assign is_end  = (rx_byte_i == SlipEnd);
  assign is_esc  = (rx_byte_i == SlipEsc);
  assign is_data = accept_i && !is_end && !is_esc;

  always_comb begin
    data_byte = rx_byte_i;
    if (esc_q) begin
      if (rx_byte_i == SlipEscapedEnd) begin
        data_byte = SlipEnd;
      end else if (rx_byte_i == SlipEscapedEsc) begin
        data_byte = SlipEsc;
      end
    end
  end

  always_comb begin
    esc_d = esc_q;
    cnt_d = cnt_q;
    if (accept_i) begin
      if (is_end) begin
        esc_d = 1'b0;
        cnt_d = '0;
      end else if (is_esc) begin
        esc_d = 1'b1;
      end else begin
        esc_d = 1'b0;
        cnt_d = (cnt_q == LastByte) ? '0 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      esc_q <= esc_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_data) begin
      asm_q[cnt_q] <= data_byte;
    end
  end

  always_comb begin
    full_bytes             = asm_q;
    full_bytes[IdBytes-1]  = data_byte;
  end

  assign evt_o.frame_end = accept_i && is_end;
  assign evt_o.id_done   = is_data && (cnt_q == LastByte);
  assign id_o.lower      = full_bytes[3:0];
  assign id_o.upper      = full_bytes[IdBytes-1:4];

endmodule

// ===== rtl/core/stic_cell.sv =====
// ----------------------------------------------------------------------------
// stic_cell
// One table entry: holds an ID, compares it, and shifts toward the head.
// ----------------------------------------------------------------------------
module stic_cell (
  input  logic                clk_i,
  input  stic_pkg::cell_ctrl_t ctrl_i,
  input  stic_pkg::id_t       cand_i,
  input  stic_pkg::id_t       nbr_id_i,
  output stic_pkg::id_t       id_o,
  output logic                match_o
);
  import stic_pkg::*;

  id_t id_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.write) begin
      id_q <= cand_i;
    end else if (ctrl_i.shift) begin
      id_q <= nbr_id_i;
    end
  end

  assign id_o    = id_q;
  assign match_o = ctrl_i.active && (id_q == cand_i);

endmodule

// ===== rtl/core/slip_tag_id_collector.sv =====
// ----------------------------------------------------------------------------
// slip_tag_id_collector
// SLIP decoder that collects unique 96-bit tag IDs and lists them per frame.
// ----------------------------------------------------------------------------
// Input channel: one raw SLIP byte per item (in_valid_i / in_ready_o).
// Output channel: one listed ID per item (out_valid_o / out_ready_i).
// After the byte that completes an ID is taken, an insert step compares the
// ID against every occupied cell at once and writes it into the first free
// cell if it is new; a new ID that finds the table full is dropped and
// flagged. An END byte starts a drain that moves one ID per cycle, while the
// receiver does not stall, out of the head cell, the chain shifting toward
// it; input is held off until the drain finishes. The first result is
// registered by the first drain step after END is taken. The output
// register lets the last result of a list wait while new bytes are accepted.
// Reset clears the escape flag, byte count, fill count, drop flag and the
// output valid flag; table cells hold no reset value and are only read below
// the fill count.
// ----------------------------------------------------------------------------
module slip_tag_id_collector #(
  parameter int unsigned TABLE_CAPACITY = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [stic_pkg::UpperW-1:0]      id_upper_o,
  output logic [stic_pkg::LowerW-1:0]      id_lower_o,
  output logic [stic_pkg::EntryIdxW-1:0]   entry_index_o,
  output logic                             is_last_o,
  output logic                             list_empty_o,
  output logic                             ids_dropped_o
);
  import stic_pkg::*;

  localparam int unsigned FillW = $clog2(TABLE_CAPACITY + 1);
  localparam logic [FillW-1:0] Cap = FillW'(TABLE_CAPACITY);

  state_e                    state_q, state_d;
  logic [FillW-1:0]          fill_q, fill_d;
  logic [FillW-1:0]          left_q, left_d;
  logic [EntryIdxW-1:0]      idx_q, idx_d;
  logic                      ovf_q, ovf_d;
  logic                      empty_q, empty_d;
  id_t                       cand_q;

  logic                      out_valid_q, out_valid_d;
  id_t                       out_id_q;
  logic [EntryIdxW-1:0]      out_idx_q;
  logic                      out_last_q, out_empty_q, out_drop_q;

  logic                      in_acc;
  logic                      load_out;
  logic                      drain_step;
  logic                      drain_last;
  logic                      insert_new;
  unslip_evt_t               evt;
  id_t                       asm_id;

  id_t                       cell_id [TABLE_CAPACITY];
  id_t                       nbr_id  [TABLE_CAPACITY];
  cell_ctrl_t                cell_ctrl [TABLE_CAPACITY];
  logic [TABLE_CAPACITY-1:0] match_vec;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  stic_unslip u_unslip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .rx_byte_i (rx_byte_i),
    .evt_o     (evt),
    .id_o      (asm_id)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && evt.id_done) begin
      cand_q <= asm_id;
    end
  end

  assign load_out   = !out_valid_q || out_ready_i;
  assign drain_step = (state_q == ST_DRAIN) && load_out;
  assign drain_last = empty_q || (left_q == FillW'(1));
  assign insert_new = (state_q == ST_INSERT) && !(|match_vec) && (fill_q < Cap);

  for (genvar i = 0; i < TABLE_CAPACITY; i++) begin : g_cell
    if (i == TABLE_CAPACITY - 1) begin : g_tail
      assign nbr_id[i] = cell_id[i];
    end else begin : g_body
      assign nbr_id[i] = cell_id[i+1];
    end

    assign cell_ctrl[i].active = (FillW'(i) < fill_q);
    assign cell_ctrl[i].write  = insert_new && (fill_q == FillW'(i));
    assign cell_ctrl[i].shift  = drain_step && !empty_q;

    stic_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl[i]),
      .cand_i   (cand_q),
      .nbr_id_i (nbr_id[i]),
      .id_o     (cell_id[i]),
      .match_o  (match_vec[i])
    );
  end

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    left_d      = left_q;
    idx_d       = idx_q;
    ovf_d       = ovf_q;
    empty_d     = empty_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && evt.frame_end) begin
          state_d = ST_DRAIN;
          left_d  = fill_q;
          empty_d = (fill_q == '0);
          idx_d   = '0;
        end else if (in_acc && evt.id_done) begin
          state_d = ST_INSERT;
        end
      end
      ST_INSERT: begin
        if (!(|match_vec)) begin
          if (fill_q < Cap) begin
            fill_d = fill_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        state_d = ST_IDLE;
      end
      ST_DRAIN: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          left_d      = left_q - 1'b1;
          idx_d       = idx_q + 1'b1;
          if (drain_last) begin
            fill_d  = '0;
            ovf_d   = 1'b0;
            left_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      left_q      <= '0;
      idx_q       <= '0;
      ovf_q       <= 1'b0;
      empty_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      left_q      <= left_d;
      idx_q       <= idx_d;
      ovf_q       <= ovf_d;
      empty_q     <= empty_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (drain_step) begin
      out_id_q    <= empty_q ? '0 : cell_id[0];
      out_idx_q   <= empty_q ? '0 : idx_q;
      out_last_q  <= drain_last;
      out_empty_q <= empty_q;
      out_drop_q  <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign id_upper_o    = out_id_q.upper;
  assign id_lower_o    = out_id_q.lower;
  assign entry_index_o = out_idx_q;
  assign is_last_o     = out_last_q;
  assign list_empty_o  = out_empty_q;
  assign ids_dropped_o = out_drop_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= Cap)
    else $error("fill count exceeds table capacity");

  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT) |-> $onehot0(match_vec))
    else $error("table holds a duplicate ID");

  a_insert_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INSERT) |=> (state_q == ST_IDLE))
    else $error("insert step did not return to idle");

  a_drain_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN && state_d == ST_IDLE) |=> (fill_q == '0 && !ovf_q))
    else $error("table not cleared after list drain");

endmodule
